[design/mtem_pkg.sv]
// Shared types and constants for the multi-tap echo mixer.
package mtem_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DELAY_W    = 13;
    localparam int ECHO_W     = 4;
    localparam int MIX_W      = 7;
    localparam int SEEN_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 2'd2;

    localparam logic [SEEN_W-1:0] SEEN_MAX = 16'hFFFF;
    localparam logic [6:0]        PERCENT  = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_WRITE,
        ST_FINISH
    } t_state;

endpackage

[design/mtem_ram.sv]
// Generic simple dual-port RAM with registered read data.
module mtem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/multi_tap_echo_mixer.sv]
// Multi-tap feed-forward echo mixer: top level with tap sequencer and history memory.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -----------------------------------
//  in        to block   i_in_valid / o_in_stall    i_in_sample, i_first_of_clip
//  out       from block o_out_valid / i_out_stall  o_out_sample
//  cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  A request walks its taps in turn: a tap out of range is skipped, a used tap is read,
//  multiplied, divided and added, the divider giving one quotient bit a cycle.
//  Reset is synchronous and clears the sequencer, write index, seen count, registers
//  and output valid; the history memory is not cleared.
//  A stalled output holds its result; the next request is taken meanwhile, and the
//  block waits only when that next result is ready.
module multi_tap_echo_mixer
    import mtem_pkg::*;
#(
    parameter int MAX_DELAY   = 4096,
    parameter int MAX_ECHOES  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  logic                          i_first_of_clip,
    // output request channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    // Sizes derived from the parameters
    localparam int DEPTH  = MAX_DELAY * MAX_ECHOES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAG_W  = $clog2(2 * DEPTH + 1);           // holds (n+1)*d
    localparam int D_W    = $clog2(MAX_DELAY + 1);
    localparam int N_W    = $clog2(MAX_ECHOES + 2);          // holds n+1
    localparam int COEF_W = N_W + MIX_W;
    localparam int NUM_W  = SAMPLE_BITS + COEF_W;
    localparam int DEN_W  = $clog2(100 * (MAX_ECHOES + 1) + 1);
    localparam int Q_W    = SAMPLE_BITS;                     // quotient < 2^SAMPLE_BITS
    localparam int DSH_W  = DEN_W + Q_W - 1;
    localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int BIT_W  = $clog2(Q_W);
    localparam int SUM_W  = SAMPLE_BITS + 2;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    // Control state
    t_state r_state, n_state;
    logic [ADDR_W-1:0]  r_wi;
    logic [SEEN_W-1:0]  r_seen;
    logic [DELAY_W-1:0] r_delay;
    logic [ECHO_W-1:0]  r_echo;
    logic [MIX_W-1:0]   r_mix;
    logic               r_out_valid;

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0] r_dry;
    logic signed [SAMPLE_BITS-1:0] r_acc;
    logic signed [SAMPLE_BITS-1:0] r_src;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic [N_W-1:0]    r_n;
    logic [N_W-1:0]    r_k;
    logic [D_W-1:0]    r_d;
    logic [LAG_W-1:0]  r_lag;
    logic [DEN_W-1:0]  r_den;
    logic [COEF_W-1:0] r_coef;
    logic [NUM_W-1:0]  r_num;
    logic [DSH_W-1:0]  r_dsh;
    logic [Q_W-1:0]    r_quo;
    logic [BIT_W-1:0]  r_bit;
    logic              r_neg;
    logic              r_zero_lag;

    // Memory port signals
    logic                   ram_we;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // Sequencer decode
    logic              in_take;
    logic              out_free;
    logic              tap_done;
    logic              tap_in_range;
    logic [LAG_W-1:0]  wi_ext;
    logic [N_W-1:0]    n_clamp;
    logic [D_W-1:0]    d_clamp;
    logic [SAMPLE_BITS-1:0] src_mag;
    logic              div_ge;
    logic signed [SUM_W-1:0] tap_val;
    logic signed [SUM_W-1:0] sum;
    logic signed [SAMPLE_BITS-1:0] sum_sat;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Clamp the registers to the sizes the history can hold
    assign n_clamp = (r_echo > MAX_ECHOES) ? N_W'(MAX_ECHOES) : N_W'(r_echo);
    assign d_clamp = (r_delay > MAX_DELAY) ? D_W'(MAX_DELAY) : D_W'(r_delay);

    // A tap is live only once its lag worth of samples of this clip has been seen
    assign tap_done     = r_k > r_n;
    assign tap_in_range = 32'(r_seen) >= 32'(r_lag);

    // Wrap the read address back from the write index by the lag
    assign wi_ext    = LAG_W'(r_wi);
    assign ram_raddr = (wi_ext >= r_lag) ? ADDR_W'(wi_ext - r_lag)
                                         : ADDR_W'(wi_ext + LAG_W'(DEPTH) - r_lag);

    assign src_mag = r_src[SAMPLE_BITS-1] ? (~r_src + 1'b1) : r_src;
    assign div_ge  = CMP_W'(r_num) >= CMP_W'(r_dsh);

    // Apply sign to the quotient, add and clip
    assign tap_val = r_neg ? -SUM_W'({1'b0, r_quo}) : SUM_W'({1'b0, r_quo});
    assign sum     = SUM_W'(r_acc) + tap_val;
    always_comb begin
        priority if (sum > SAT_MAX) begin
            sum_sat = SAMPLE_BITS'(SAT_MAX);
        end else if (sum < SAT_MIN) begin
            sum_sat = SAMPLE_BITS'(SAT_MIN);
        end else begin
            sum_sat = SAMPLE_BITS'(sum);
        end
    end

    // Next state and control outputs
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = ST_TAP;
                end
            end
            ST_TAP: begin
                if (tap_done) begin
                    n_state = ST_WRITE;
                end else if (tap_in_range) begin
                    ram_re  = (r_lag != '0);
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD:  n_state = ST_TAP;
            ST_WRITE: begin
                ram_we  = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_echo  <= '0;
            r_mix   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DELAY: r_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_ECHO:  r_echo  <= i_cfg_data[ECHO_W-1:0];
                CFG_MIX:   r_mix   <= i_cfg_data[MIX_W-1:0];
                default:   ;
            endcase
        end
    end

    // Write index, seen count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi        <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new clip forgets the history before this sample is used
            if (in_take && i_first_of_clip) begin
                r_seen <= '0;
            end
            if (r_state == ST_WRITE) begin
                r_wi <= (32'(r_wi) == DEPTH - 1) ? '0 : r_wi + 1'b1;
                if (r_seen != SEEN_MAX) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Tap datapath: coefficient, product, restoring division, accumulate
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_dry <= i_in_sample;
                r_acc <= i_in_sample;
                r_n   <= n_clamp;
                r_d   <= d_clamp;
                r_k   <= N_W'(1);
                r_lag <= LAG_W'(d_clamp);
                r_den <= DEN_W'(n_clamp + 1'b1) * DEN_W'(PERCENT);
            end
            ST_TAP: begin
                r_zero_lag <= (r_lag == '0);
                r_coef     <= COEF_W'(N_W'(r_n - r_k + 1'b1)) * COEF_W'(r_mix);
                if (!tap_done && !tap_in_range) begin
                    r_k   <= r_k + 1'b1;
                    r_lag <= r_lag + LAG_W'(r_d);
                end
            end
            ST_READ: begin
                r_src <= r_zero_lag ? r_dry : ram_rdata;
            end
            ST_MUL: begin
                r_num <= NUM_W'(src_mag) * NUM_W'(r_coef);
                r_neg <= r_src[SAMPLE_BITS-1];
                r_dsh <= DSH_W'(r_den) << (Q_W - 1);
                r_quo <= '0;
                r_bit <= BIT_W'(Q_W - 1);
            end
            ST_DIV: begin
                if (div_ge) begin
                    r_num <= r_num - NUM_W'(r_dsh);
                end
                r_quo <= {r_quo[Q_W-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - 1'b1;
            end
            ST_ADD: begin
                r_acc <= sum_sat;
                r_k   <= r_k + 1'b1;
                r_lag <= r_lag + LAG_W'(r_d);
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_out_sample <= r_acc;
                end
            end
            default: ;
        endcase
    end

    mtem_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wi),
        .i_wdata (r_dry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

`ifndef NO_ASSERTIONS
    // History is never read and written in the same cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("history read and write collide");

    // An accepted request starts the tap walk
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == ST_TAP)
        else $error("accepted request did not start tap walk");

    // Accumulate only after the last quotient bit
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD |-> $past(r_state) == ST_DIV && $past(r_bit) == '0)
        else $error("quotient added before division finished");

    // A new result appears only from the finishing step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("result shown without finishing step");

    // Taps never run past the configured count
    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |-> r_k <= r_n)
        else $error("tap index beyond echo count");
`endif

endmodule

[tb/mtem_echo_checker.sv]
// Channel monitor, echo predictor and result comparator for the multi-tap echo mixer.
module mtem_echo_checker
    import mtem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic signed [15:0]    i_in_sample,
    input  logic                  i_first_of_clip,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic signed [15:0]    i_out_sample,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int HIST_DEPTH  = 4096 * 8;
    localparam int DELAY_LIMIT = 4096;
    localparam int TAP_LIMIT   = 8;

    logic signed [15:0] dry_hist [HIST_DEPTH];
    int                 hist_ptr;
    int                 clip_seen;
    logic [DELAY_W-1:0] delay_reg;
    logic [ECHO_W-1:0]  taps_reg;
    logic [MIX_W-1:0]   wet_reg;

    logic signed [15:0] mix_due [$];
    logic signed [15:0] want_sample;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic flag_mismatch(input string what);
        o_fail_count++;
        $display("%0t: %s", $time, what);
    endtask

    // Dry sample plus weighted, gated taps; saturate after every add.
    function automatic logic signed [15:0] echo_sum(input logic signed [15:0] dry,
                                                    input logic restart);
        int     n;
        int     d;
        int     k;
        int     lag;
        longint acc;
        longint src;
        longint tap;
        longint denom;
        n     = (taps_reg > TAP_LIMIT) ? TAP_LIMIT : int'(taps_reg);
        d     = (delay_reg > DELAY_LIMIT) ? DELAY_LIMIT : int'(delay_reg);
        denom = 100 * (n + 1);
        acc   = dry;
        if (restart)
            clip_seen = 0;
        for (k = 1; k <= n; k++) begin
            lag = k * d;
            if (clip_seen >= lag) begin
                if (lag == 0)
                    src = dry;
                else
                    src = dry_hist[(hist_ptr + HIST_DEPTH - lag) % HIST_DEPTH];
                tap = (src * longint'(n + 1 - k) * longint'(wet_reg)) / denom;
                acc = acc + tap;
                if (acc > 32767)
                    acc = 32767;
                else if (acc < -32768)
                    acc = -32768;
            end
        end
        dry_hist[hist_ptr] = dry;
        hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        if (clip_seen < 65535)
            clip_seen++;
        return acc[15:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist_ptr  = 0;
            clip_seen = 0;
            delay_reg = '0;
            taps_reg  = '0;
            wet_reg   = '0;
            mix_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELAY: delay_reg = i_cfg_data[DELAY_W-1:0];
                    CFG_ECHO:  taps_reg  = i_cfg_data[ECHO_W-1:0];
                    CFG_MIX:   wet_reg   = i_cfg_data[MIX_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (mix_due.size() == 0) begin
                    flag_mismatch($sformatf("output request %0d with nothing outstanding",
                                            i_out_sample));
                end else begin
                    want_sample = mix_due.pop_front();
                    if (i_out_sample !== want_sample)
                        flag_mismatch($sformatf("out_sample got %0d want %0d",
                                                i_out_sample, want_sample));
                end
            end
            if (i_in_valid && !i_in_stall)
                mix_due.push_back(echo_sum(i_in_sample, i_first_of_clip));
        end
        o_pending <= mix_due.size();
    end

endmodule

[tb/tb_multi_tap_echo_mixer.sv]
// Stimulus, reset, clocking and verdict for the multi-tap echo mixer testbench.
module tb_multi_tap_echo_mixer;
    import mtem_pkg::*;

    // generous ceiling: every request at eight live taps, long stalls and gaps, times several
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // a little more than the longest request at eight taps
    localparam int          DRAIN_CYCLES = 200;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [15:0]    in_sample;
    logic                  in_first;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [15:0]    out_sample;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          pending;
    int          fail_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycles = 0;

    multi_tap_echo_mixer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_in_sample     (in_sample),
        .i_first_of_clip (in_first),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_sample    (out_sample),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    mtem_echo_checker checker_u (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_sample     (in_sample),
        .i_first_of_clip (in_first),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_sample    (out_sample),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    always #6 clk = ~clk;

    // Watchdog: give up if the run hangs, e.g. a result never turns up.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver back-pressure: stall at random at the rate of the current idling phase.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default:   begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endtask

    // Offer one request; hold it steady until the block takes it. Call just after an edge.
    task automatic push_sample(input logic signed [15:0] smp, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= smp;
        in_first  <= first;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and hold off until every expected result has been taken.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers back to back; only while the block is idle.
    task automatic program_regs(input int delay, input int echoes, input int wet);
        logic [CFG_IDX_W-1:0]  idx  [3];
        logic [CFG_DATA_W-1:0] vals [3];
        int                    i;
        idx[0]  = CFG_DELAY;
        idx[1]  = CFG_ECHO;
        idx[2]  = CFG_MIX;
        vals[0] = delay[CFG_DATA_W-1:0];
        vals[1] = echoes[CFG_DATA_W-1:0];
        vals[2] = wet[CFG_DATA_W-1:0];
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly full-range audio, with rails and near-zero values mixed in.
    function automatic logic signed [15:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'(int'($urandom_range(0, 64)) - 32);
            default: return r[15:0];
        endcase
    endfunction

    // Well-formed clips with random content and a zero tail, plus odd broken starts.
    task automatic run_phase(input int delay, input int echoes,
                             input int count, input bit pause_mid);
        int  sent;
        int  reach;
        int  clip_len;
        int  tail_len;
        int  i;
        bit  paused;
        logic first;
        sent   = 0;
        paused = 1'b0;
        reach  = ((delay > 4096) ? 4096 : delay) * ((echoes > 8) ? 8 : echoes) + 8;
        if (reach > 300)
            reach = 300;
        while (sent < count) begin
            clip_len = $urandom_range(1, reach);
            if (clip_len > count - sent)
                clip_len = count - sent;
            tail_len = $urandom_range(0, clip_len / 2);
            for (i = 0; i < clip_len; i++) begin
                // now and then skip the clip marker or restart a clip half way
                if (i == 0)
                    first = ($urandom_range(0, 9) != 0);
                else
                    first = ($urandom_range(0, 49) == 0);
                if (i >= clip_len - tail_len)
                    push_sample(16'sd0, first);
                else
                    push_sample(pick_sample(), first);
                sent++;
                if (pause_mid && !paused && sent >= count / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        int p;
        int delay;
        int echoes;
        int wet;
        int count;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_sample = '0;
        in_first  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DELAY;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, light idling on both sides.
        set_idling(IDLE_BOTH);

        // zero delay: every tap reads the current request; full taps and full wet level
        program_regs(0, 8, 100);
        push_sample(16'sh7FFF, 1'b1);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd12345, 1'b0);
        settle();

        // echo count above the tap limit, mix above one hundred percent
        program_regs(0, 15, 127);
        push_sample(16'sh7FFF, 1'b1);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd100, 1'b0);
        settle();

        // delay above the limit; taps never reached, mix at zero
        program_regs(8191, 1, 0);
        push_sample(16'sd5, 1'b1);
        push_sample(-16'sd7, 1'b0);
        settle();

        // short delay: taps come in one by one, then a restart clears the seen count
        program_regs(1, 3, 100);
        push_sample(16'sd20000, 1'b1);
        push_sample(-16'sd20000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd1000, 1'b1);
        push_sample(16'sd0, 1'b0);
        settle();

        // no taps: output is the dry request
        program_regs(3, 0, 100);
        push_sample(16'sd300, 1'b1);
        push_sample(-16'sd300, 1'b0);
        settle();

        // Random part: cycle through idling phases and register settings.
        for (p = 0; p < 12; p++) begin
            set_idling(t_idle_mode'(p % 4));
            case (p)
                0:       begin delay = 0;    echoes = 8;  wet = 100; end
                1:       begin delay = 1;    echoes = 15; wet = 127; end
                2:       begin delay = 100;  echoes = 2;  wet = 73;  end
                3:       begin delay = 8191; echoes = 15; wet = 0;   end
                4:       begin delay = 4096; echoes = 8;  wet = 50;  end
                default: begin
                    delay  = $urandom_range(0, 30);
                    echoes = $urandom_range(0, 15);
                    wet    = $urandom_range(0, 127);
                end
            endcase
            // the phase with a delay of 100 needs long clips before its taps come alive
            count = (p == 2) ? 250 : 100;
            program_regs(delay, echoes, wet);
            run_phase(delay, echoes, count, p == 5);
            settle();
        end

        // Let any stray result show itself before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
design/mtem_pkg.sv
design/mtem_ram.sv
design/multi_tap_echo_mixer.sv
tb/mtem_echo_checker.sv
tb/tb_multi_tap_echo_mixer.sv
